>>> hdl/cpt_pkg.sv
// types, widths and region codes shared by the closest-point blocks
`timescale 1ns / 1ps
`default_nettype none
package cpt_pkg;

   localparam int FRAC_BITS = 16;
   localparam int COORD_W  = 32;
   localparam int DIFF_W   = 33;
   localparam int PROD_W   = 66;
   localparam int DOT_W    = 68;
   localparam int HALF_W   = 34;
   localparam int LIMB_W   = 35;
   localparam int PART_W   = 70;
   localparam int PAIR_W   = 136;
   localparam int NUM_W    = 140;
   localparam int REGION_W = 3;
   localparam int WEIGHT_W = FRAC_BITS + 1;

   localparam logic [REGION_W-1:0] REGION_VERTEX_A = 3'd0;
   localparam logic [REGION_W-1:0] REGION_VERTEX_B = 3'd1;
   localparam logic [REGION_W-1:0] REGION_VERTEX_C = 3'd2;
   localparam logic [REGION_W-1:0] REGION_EDGE_AB  = 3'd3;
   localparam logic [REGION_W-1:0] REGION_EDGE_AC  = 3'd4;
   localparam logic [REGION_W-1:0] REGION_EDGE_BC  = 3'd5;
   localparam logic [REGION_W-1:0] REGION_INTERIOR = 3'd6;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic signed [NUM_W-1:0]   num_type;

   typedef struct packed {
      coord_type vertex_a_x;
      coord_type vertex_a_y;
      coord_type vertex_a_z;
      coord_type vertex_b_x;
      coord_type vertex_b_y;
      coord_type vertex_b_z;
      coord_type vertex_c_x;
      coord_type vertex_c_y;
      coord_type vertex_c_z;
      coord_type query_x;
      coord_type query_y;
      coord_type query_z;
   } req_type;

   typedef struct packed {
      coord_type             closest_x;
      coord_type             closest_y;
      coord_type             closest_z;
      logic [REGION_W-1:0]   region;
      logic [WEIGHT_W-1:0]   weight_a;
      logic [WEIGHT_W-1:0]   weight_b;
      logic [WEIGHT_W-1:0]   weight_c;
   } rsp_type;

   // classified word handed from the front to the back
   typedef struct packed {
      logic [REGION_W-1:0]   region;
      coord_type [2:0]       base;
      diff_type [2:0]        vec1;
      diff_type [2:0]        vec2;
      num_type               num1;
      num_type               num2;
      num_type               den;
   } work_type;

   function automatic logic is_neg_or_zero(input num_type x);
      return x[NUM_W-1] | (x == '0);
   endfunction

   function automatic logic is_non_neg(input num_type x);
      return ~x[NUM_W-1];
   endfunction

endpackage
`default_nettype wire

>>> hdl/closest_point_on_triangle.sv
// closest point on a triangle with region code and barycentric weights
// pipeline: 8 front stages, the word queue, FRAC_BITS divider stages, 3 back stages
// throughput: one word per cycle while nothing stalls; both dividers are pipelined
//   one quotient bit a stage
// the front stalls only when the queue is full, the back only when the result waits
// reset clears all valid bits and queue pointers; there is no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module closest_point_on_triangle #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  cpt_pkg::req_type req_data,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output cpt_pkg::rsp_type rsp_data
);
   import cpt_pkg::*;

   logic     q_full, q_empty, q_pop, front_valid, back_valid;
   work_type front_data, q_data;

   cpt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (~q_full),
      .in_valid  (req_push),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   cpt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_valid & ~q_full),
      .in_data  (front_data),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .out_data (q_data)
   );

   cpt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (~q_empty),
      .in_data   (q_data),
      .in_take   (q_pop),
      .out_pop   (rsp_pop),
      .out_valid (back_valid),
      .out_data  (rsp_data)
   );

   assign req_full  = q_full;
   assign rsp_empty = ~back_valid;

endmodule
`default_nettype wire

>>> hdl/cpt_front.sv
// front pipeline: differences, dot products, cross terms and region select
`timescale 1ns / 1ps
`default_nettype none
module cpt_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  cpt_pkg::req_type  in_data,
   output logic              out_valid,
   output cpt_pkg::work_type out_data
);
   import cpt_pkg::*;

   localparam int STAGES = 8;

   typedef struct packed {
      coord_type [2:0] a;
      coord_type [2:0] b;
      coord_type [2:0] c;
      diff_type [2:0]  ab;
      diff_type [2:0]  ac;
      diff_type [2:0]  bc;
   } geo_type;

   localparam int PAIR_L [6] = '{0, 1, 1, 0, 2, 3};
   localparam int PAIR_R [6] = '{3, 2, 4, 5, 5, 4};

   logic [STAGES-1:0] valid_ff, valid_in;

   coord_type pa [3];
   coord_type pb [3];
   coord_type pc [3];
   coord_type pq [3];
   geo_type   geo_in;
   diff_type  ap_in [3];
   diff_type  bp_in [3];
   diff_type  cp_in [3];

   geo_type   geo_ff [1:STAGES-1];
   diff_type  ap_ff [3];
   diff_type  bp_ff [3];
   diff_type  cp_ff [3];

   logic signed [PROD_W-1:0] prod_in [6][3];
   logic signed [PROD_W-1:0] prod_ff [6][3];
   logic signed [DOT_W-1:0]  dot3_in [6];
   logic signed [DOT_W-1:0]  dot3_ff [6];
   logic signed [DOT_W-1:0]  dot4_ff [6];
   logic signed [DOT_W-1:0]  dot5_ff [6];
   logic signed [PART_W-1:0] part_in [6][4];
   logic signed [PART_W-1:0] part_ff [6][4];
   logic signed [PAIR_W-1:0] pair_in [6];
   logic signed [PAIR_W-1:0] pair_ff [6];

   num_type vp0_ff, vp1_ff, vp2_ff, e43_ff, e56_ff, d13_ff, d26_ff;
   num_type d1_ff, d2_ff, d3_ff, d6_ff;

   logic [5:0] flag_in, flag_ff;
   num_type    ab_n_ff, ab_d_ff, ac_n_ff, ac_d_ff, bc_n_ff, bc_d_ff;
   num_type    in_u_ff, in_v_ff, in_d_ff;

   work_type   work_in, work_ff;

   function automatic num_type floor_one(input num_type x);
      return is_neg_or_zero(x) ? num_type'(1) : x;
   endfunction

   assign valid_in = {valid_ff[STAGES-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   // stage 1: edge and query vectors
   always_comb begin
      pa[0] = in_data.vertex_a_x;  pa[1] = in_data.vertex_a_y;  pa[2] = in_data.vertex_a_z;
      pb[0] = in_data.vertex_b_x;  pb[1] = in_data.vertex_b_y;  pb[2] = in_data.vertex_b_z;
      pc[0] = in_data.vertex_c_x;  pc[1] = in_data.vertex_c_y;  pc[2] = in_data.vertex_c_z;
      pq[0] = in_data.query_x;     pq[1] = in_data.query_y;     pq[2] = in_data.query_z;
      for (int i = 0; i < 3; i++) begin
         geo_in.a[i]  = pa[i];
         geo_in.b[i]  = pb[i];
         geo_in.c[i]  = pc[i];
         geo_in.ab[i] = DIFF_W'(pb[i]) - DIFF_W'(pa[i]);
         geo_in.ac[i] = DIFF_W'(pc[i]) - DIFF_W'(pa[i]);
         geo_in.bc[i] = DIFF_W'(pc[i]) - DIFF_W'(pb[i]);
         ap_in[i]     = DIFF_W'(pq[i]) - DIFF_W'(pa[i]);
         bp_in[i]     = DIFF_W'(pq[i]) - DIFF_W'(pb[i]);
         cp_in[i]     = DIFF_W'(pq[i]) - DIFF_W'(pc[i]);
      end
   end

   // stage 2: coordinate products, stage 3: dot sums
   always_comb begin
      for (int j = 0; j < 6; j++) begin
         for (int i = 0; i < 3; i++) begin
            if (j / 2 == 0) begin
               prod_in[j][i] = ((j % 2 == 0) ? $signed(geo_ff[1].ab[i])
                                             : $signed(geo_ff[1].ac[i])) * ap_ff[i];
            end else if (j / 2 == 1) begin
               prod_in[j][i] = ((j % 2 == 0) ? $signed(geo_ff[1].ab[i])
                                             : $signed(geo_ff[1].ac[i])) * bp_ff[i];
            end else begin
               prod_in[j][i] = ((j % 2 == 0) ? $signed(geo_ff[1].ab[i])
                                             : $signed(geo_ff[1].ac[i])) * cp_ff[i];
            end
         end
         dot3_in[j] = DOT_W'(prod_ff[j][0]) + DOT_W'(prod_ff[j][1]) + DOT_W'(prod_ff[j][2]);
      end
   end

   // stage 4: split cross products into limb partials, stage 5: recombine
   always_comb begin
      for (int p = 0; p < 6; p++) begin
         logic signed [LIMB_W-1:0] hx, lx, hy, ly;
         hx = LIMB_W'($signed(dot3_ff[PAIR_L[p]][DOT_W-1:HALF_W]));
         lx = {1'b0, dot3_ff[PAIR_L[p]][HALF_W-1:0]};
         hy = LIMB_W'($signed(dot3_ff[PAIR_R[p]][DOT_W-1:HALF_W]));
         ly = {1'b0, dot3_ff[PAIR_R[p]][HALF_W-1:0]};
         part_in[p][0] = hx * hy;
         part_in[p][1] = hx * ly;
         part_in[p][2] = lx * hy;
         part_in[p][3] = lx * ly;
         pair_in[p] = (PAIR_W'(part_ff[p][0]) <<< (2 * HALF_W))
                    + ((PAIR_W'(part_ff[p][1]) + PAIR_W'(part_ff[p][2])) <<< HALF_W)
                    + PAIR_W'(part_ff[p][3]);
      end
   end

   // stage 7: region tests
   always_comb begin
      flag_in[0] = is_neg_or_zero(d1_ff) & is_neg_or_zero(d2_ff);
      flag_in[1] = is_non_neg(d3_ff) & is_neg_or_zero(e43_ff);
      flag_in[2] = is_non_neg(d6_ff) & is_neg_or_zero(e56_ff);
      flag_in[3] = is_neg_or_zero(vp2_ff) & is_non_neg(d1_ff) & is_neg_or_zero(d3_ff);
      flag_in[4] = is_neg_or_zero(vp1_ff) & is_non_neg(d2_ff) & is_neg_or_zero(d6_ff);
      flag_in[5] = is_neg_or_zero(vp0_ff) & is_non_neg(e43_ff) & is_non_neg(e56_ff);
   end

   // stage 8: first matching region wins
   always_comb begin
      work_in.region = REGION_INTERIOR;
      work_in.base   = geo_ff[7].a;
      work_in.vec1   = geo_ff[7].ab;
      work_in.vec2   = geo_ff[7].ac;
      work_in.num1   = in_u_ff;
      work_in.num2   = in_v_ff;
      work_in.den    = floor_one(in_d_ff);
      if (flag_ff[0]) begin
         work_in.region = REGION_VERTEX_A;
         work_in.num1   = '0;
         work_in.num2   = '0;
         work_in.den    = num_type'(1);
      end else if (flag_ff[1]) begin
         work_in.region = REGION_VERTEX_B;
         work_in.base   = geo_ff[7].b;
         work_in.num1   = '0;
         work_in.num2   = '0;
         work_in.den    = num_type'(1);
      end else if (flag_ff[2]) begin
         work_in.region = REGION_VERTEX_C;
         work_in.base   = geo_ff[7].c;
         work_in.num1   = '0;
         work_in.num2   = '0;
         work_in.den    = num_type'(1);
      end else if (flag_ff[3]) begin
         work_in.region = REGION_EDGE_AB;
         work_in.num1   = ab_n_ff;
         work_in.num2   = '0;
         work_in.den    = floor_one(ab_d_ff);
      end else if (flag_ff[4]) begin
         work_in.region = REGION_EDGE_AC;
         work_in.vec1   = geo_ff[7].ac;
         work_in.num1   = ac_n_ff;
         work_in.num2   = '0;
         work_in.den    = floor_one(ac_d_ff);
      end else if (flag_ff[5]) begin
         work_in.region = REGION_EDGE_BC;
         work_in.base   = geo_ff[7].b;
         work_in.vec1   = geo_ff[7].bc;
         work_in.num1   = bc_n_ff;
         work_in.num2   = '0;
         work_in.den    = floor_one(bc_d_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         geo_ff[1] <= geo_in;
         for (int k = 2; k < STAGES; k++) begin
            geo_ff[k] <= geo_ff[k-1];
         end
         for (int i = 0; i < 3; i++) begin
            ap_ff[i] <= ap_in[i];
            bp_ff[i] <= bp_in[i];
            cp_ff[i] <= cp_in[i];
         end
         prod_ff <= prod_in;
         dot3_ff <= dot3_in;
         dot4_ff <= dot3_ff;
         dot5_ff <= dot4_ff;
         part_ff <= part_in;
         pair_ff <= pair_in;

         vp2_ff <= NUM_W'(pair_ff[0]) - NUM_W'(pair_ff[1]);
         vp1_ff <= NUM_W'(pair_ff[2]) - NUM_W'(pair_ff[3]);
         vp0_ff <= NUM_W'(pair_ff[4]) - NUM_W'(pair_ff[5]);
         e43_ff <= NUM_W'(dot5_ff[3]) - NUM_W'(dot5_ff[2]);
         e56_ff <= NUM_W'(dot5_ff[4]) - NUM_W'(dot5_ff[5]);
         d13_ff <= NUM_W'(dot5_ff[0]) - NUM_W'(dot5_ff[2]);
         d26_ff <= NUM_W'(dot5_ff[1]) - NUM_W'(dot5_ff[5]);
         d1_ff  <= NUM_W'(dot5_ff[0]);
         d2_ff  <= NUM_W'(dot5_ff[1]);
         d3_ff  <= NUM_W'(dot5_ff[2]);
         d6_ff  <= NUM_W'(dot5_ff[5]);

         flag_ff <= flag_in;
         ab_n_ff <= d1_ff;
         ab_d_ff <= d13_ff;
         ac_n_ff <= d2_ff;
         ac_d_ff <= d26_ff;
         bc_n_ff <= e43_ff;
         bc_d_ff <= e43_ff + e56_ff;
         in_u_ff <= vp1_ff;
         in_v_ff <= vp2_ff;
         in_d_ff <= vp0_ff + vp1_ff + vp2_ff;

         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_data  = work_ff;

endmodule
`default_nettype wire

>>> hdl/cpt_queue.sv
// short word queue between the front and back pipelines
`timescale 1ns / 1ps
`default_nettype none
module cpt_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cpt_pkg::work_type in_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output cpt_pkg::work_type out_data
);
   import cpt_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   work_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign out_data = mem_ff[rd_ptr_ff];

endmodule
`default_nettype wire

>>> hdl/cpt_back.sv
// back pipeline: restoring dividers, interpolation and weight output
`timescale 1ns / 1ps
`default_nettype none
module cpt_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  cpt_pkg::work_type in_data,
   output logic              in_take,
   input  logic              out_pop,
   output logic              out_valid,
   output cpt_pkg::rsp_type  out_data
);
   import cpt_pkg::*;

   localparam int LAST  = FRAC_BITS + 2;
   localparam int MUL_W = FRAC_BITS + 2 + DIFF_W;
   localparam int SUM_W = MUL_W + 1;
   localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) <<< (FRAC_BITS - 1);

   typedef struct packed {
      logic [REGION_W-1:0] region;
      coord_type [2:0]     base;
      diff_type [2:0]      vec1;
      diff_type [2:0]      vec2;
      logic                zero1;
      logic                one1;
      logic                zero2;
      logic                one2;
   } pay_type;

   logic              en;
   logic [LAST:0]     valid_ff;

   pay_type              pay_ff  [FRAC_BITS+2];
   logic [NUM_W-1:0]     den_ff  [FRAC_BITS+1];
   logic [NUM_W-1:0]     rem1_ff [FRAC_BITS+1];
   logic [NUM_W-1:0]     rem2_ff [FRAC_BITS+1];
   logic [FRAC_BITS-1:0] q1_ff   [FRAC_BITS+1];
   logic [FRAC_BITS-1:0] q2_ff   [FRAC_BITS+1];
   logic [NUM_W-1:0]     rem1_in [FRAC_BITS];
   logic [NUM_W-1:0]     rem2_in [FRAC_BITS];
   logic                 bit1_in [FRAC_BITS];
   logic                 bit2_in [FRAC_BITS];

   pay_type              pay0_in;
   logic [FRAC_BITS:0]   f1_in, f2_in, f1_ff, f2_ff;
   logic signed [MUL_W-1:0] prod1_in [3];
   logic signed [MUL_W-1:0] prod2_in [3];
   logic signed [MUL_W-1:0] prod1_ff [3];
   logic signed [MUL_W-1:0] prod2_ff [3];

   rsp_type rsp_in, rsp_ff;
   coord_type clo [3];

   assign en      = ~valid_ff[LAST] | out_pop;
   assign in_take = en & in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[LAST-1:0], in_valid};
      end
   end

   // entry: saturation tests of both ratios
   always_comb begin
      pay0_in.region = in_data.region;
      pay0_in.base   = in_data.base;
      pay0_in.vec1   = in_data.vec1;
      pay0_in.vec2   = in_data.vec2;
      pay0_in.zero1  = is_neg_or_zero(in_data.num1);
      pay0_in.one1   = is_non_neg(in_data.num1 - in_data.den);
      pay0_in.zero2  = is_neg_or_zero(in_data.num2);
      pay0_in.one2   = is_non_neg(in_data.num2 - in_data.den);
   end

   // one quotient bit per stage
   always_comb begin
      for (int k = 0; k < FRAC_BITS; k++) begin
         logic [NUM_W-1:0] sh1, sh2;
         sh1 = {rem1_ff[k][NUM_W-2:0], 1'b0};
         sh2 = {rem2_ff[k][NUM_W-2:0], 1'b0};
         bit1_in[k] = (sh1 >= den_ff[k]);
         bit2_in[k] = (sh2 >= den_ff[k]);
         rem1_in[k] = bit1_in[k] ? sh1 - den_ff[k] : sh1;
         rem2_in[k] = bit2_in[k] ? sh2 - den_ff[k] : sh2;
      end
   end

   // ratio select and scaling of the edge vectors
   always_comb begin
      f1_in = pay_ff[FRAC_BITS].zero1 ? '0 :
              pay_ff[FRAC_BITS].one1  ? ONE : {1'b0, q1_ff[FRAC_BITS]};
      f2_in = pay_ff[FRAC_BITS].zero2 ? '0 :
              pay_ff[FRAC_BITS].one2  ? ONE : {1'b0, q2_ff[FRAC_BITS]};
      for (int i = 0; i < 3; i++) begin
         prod1_in[i] = $signed({1'b0, f1_in}) * $signed(pay_ff[FRAC_BITS].vec1[i]);
         prod2_in[i] = $signed({1'b0, f2_in}) * $signed(pay_ff[FRAC_BITS].vec2[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pay_ff[0]  <= pay0_in;
         den_ff[0]  <= in_data.den;
         rem1_ff[0] <= in_data.num1;
         rem2_ff[0] <= in_data.num2;
         q1_ff[0]   <= '0;
         q2_ff[0]   <= '0;
         for (int k = 0; k < FRAC_BITS; k++) begin
            pay_ff[k+1]  <= pay_ff[k];
            den_ff[k+1]  <= den_ff[k];
            rem1_ff[k+1] <= rem1_in[k];
            rem2_ff[k+1] <= rem2_in[k];
            q1_ff[k+1]   <= {q1_ff[k][FRAC_BITS-2:0], bit1_in[k]};
            q2_ff[k+1]   <= {q2_ff[k][FRAC_BITS-2:0], bit2_in[k]};
         end
         pay_ff[FRAC_BITS+1] <= pay_ff[FRAC_BITS];
         f1_ff    <= f1_in;
         f2_ff    <= f2_in;
         prod1_ff <= prod1_in;
         prod2_ff <= prod2_in;
         rsp_ff   <= rsp_in;
      end
   end

   // round to nearest, add base point, clamp to 32 bits
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic signed [SUM_W-1:0] acc, tot;
         logic [SUM_W-COORD_W:0]  top;
         acc = SUM_W'(prod1_ff[i]) + SUM_W'(prod2_ff[i]) + RND;
         tot = (acc >>> FRAC_BITS) + SUM_W'($signed(pay_ff[FRAC_BITS+1].base[i]));
         top = tot[SUM_W-1:COORD_W-1];
         if ((&top) | ~(|top)) begin
            clo[i] = tot[COORD_W-1:0];
         end else if (tot[SUM_W-1]) begin
            clo[i] = {1'b1, {(COORD_W-1){1'b0}}};
         end else begin
            clo[i] = {1'b0, {(COORD_W-1){1'b1}}};
         end
      end
   end

   always_comb begin
      logic signed [FRAC_BITS+2:0] wint;
      logic [FRAC_BITS:0]          wrest, wclip;
      wint  = $signed({2'b00, ONE}) - $signed({2'b00, f1_ff}) - $signed({2'b00, f2_ff});
      wclip = wint[FRAC_BITS+2] ? '0 : wint[FRAC_BITS:0];
      wrest = ONE - f1_ff;
      rsp_in.closest_x = clo[0];
      rsp_in.closest_y = clo[1];
      rsp_in.closest_z = clo[2];
      rsp_in.region    = pay_ff[FRAC_BITS+1].region;
      rsp_in.weight_a  = '0;
      rsp_in.weight_b  = '0;
      rsp_in.weight_c  = '0;
      case (pay_ff[FRAC_BITS+1].region)
         REGION_VERTEX_A: rsp_in.weight_a = WEIGHT_W'(ONE);
         REGION_VERTEX_B: rsp_in.weight_b = WEIGHT_W'(ONE);
         REGION_VERTEX_C: rsp_in.weight_c = WEIGHT_W'(ONE);
         REGION_EDGE_AB: begin
            rsp_in.weight_a = WEIGHT_W'(wrest);
            rsp_in.weight_b = WEIGHT_W'(f1_ff);
         end
         REGION_EDGE_AC: begin
            rsp_in.weight_a = WEIGHT_W'(wrest);
            rsp_in.weight_c = WEIGHT_W'(f1_ff);
         end
         REGION_EDGE_BC: begin
            rsp_in.weight_b = WEIGHT_W'(wrest);
            rsp_in.weight_c = WEIGHT_W'(f1_ff);
         end
         REGION_INTERIOR: begin
            rsp_in.weight_a = WEIGHT_W'(wclip);
            rsp_in.weight_b = WEIGHT_W'(f1_ff);
            rsp_in.weight_c = WEIGHT_W'(f2_ff);
         end
         default: begin
            rsp_in.weight_a = '0;
         end
      endcase
   end

   assign out_valid = valid_ff[LAST];
   assign out_data  = rsp_ff;

endmodule
`default_nettype wire

>>> hdl/cpt_checker.sv
// port checks for the closest-point block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module cpt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_full,
   input logic             rsp_pop,
   input logic             rsp_empty,
   input cpt_pkg::rsp_type rsp_data
);
   import cpt_pkg::*;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queue or output not cleared by reset");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed or vanished");

   a_vertex_weights: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |->
         ((rsp_data.region != REGION_VERTEX_A) ||
          (rsp_data.weight_b == '0 && rsp_data.weight_c == '0)) &&
         ((rsp_data.region != REGION_VERTEX_B) ||
          (rsp_data.weight_a == '0 && rsp_data.weight_c == '0)) &&
         ((rsp_data.region != REGION_VERTEX_C) ||
          (rsp_data.weight_a == '0 && rsp_data.weight_b == '0)))
      else $error("vertex region with weight on another vertex");

   a_edge_weights: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |->
         ((rsp_data.region != REGION_EDGE_AB) || (rsp_data.weight_c == '0)) &&
         ((rsp_data.region != REGION_EDGE_AC) || (rsp_data.weight_b == '0)) &&
         ((rsp_data.region != REGION_EDGE_BC) || (rsp_data.weight_a == '0)))
      else $error("edge region with weight on the vertex off the edge");

endmodule

bind closest_point_on_triangle cpt_checker u_cpt_checker (.*);
`default_nettype wire

>>> tb/closest_point_on_triangle_tb.sv
// self-checking bench for closest_point_on_triangle: random and directed triangles
`timescale 1ns / 1ps
`default_nettype none
module closest_point_on_triangle_tb;
   import cpt_pkg::*;

   localparam int FRAC     = FRAC_BITS;
   localparam int LATENCY  = FRAC + 12;
   localparam int N_RANDOM = 1500;
   localparam int LIMIT    = 400000;
   localparam longint ONE_Q = longint'(1) << FRAC;

   typedef logic signed [159:0] wide_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_pop = 1'b0;
   logic    rsp_empty;
   rsp_type rsp_data;

   req_type pending_words[$];
   rsp_type expected_points[$];
   int      n_accepted = 0;
   int      n_checked = 0;
   int      n_errors = 0;
   int      n_cycles = 0;
   int      hold_cycles = 0;
   bit      held_once = 1'b0;
   int      region_hits[7];

   closest_point_on_triangle i_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_pop(rsp_pop), .rsp_empty(rsp_empty), .rsp_data(rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic wide_type dot3(input longint x[3], input longint y[3]);
      wide_type s;
      s = 0;
      for (int i = 0; i < 3; i++) s += wide_type'(x[i]) * wide_type'(y[i]);
      return s;
   endfunction

   function automatic wide_type floor_one(input wide_type x);
      return (x <= 0) ? wide_type'(1) : x;
   endfunction

   // saturated fraction n/d as unsigned Q1.FRAC, d positive
   function automatic longint sat_ratio(input wide_type n, input wide_type d);
      longint q;
      q = 0;
      if (n <= 0) return 0;
      if (d <= n) return ONE_Q;
      for (int i = 0; i < FRAC; i++) begin
         n = n <<< 1;
         q = q << 1;
         if (d <= n) begin
            n = n - d;
            q = q | 1;
         end
      end
      return q;
   endfunction

   function automatic longint round_q(input longint p);
      return (p + (longint'(1) << (FRAC - 1))) >>> FRAC;
   endfunction

   function automatic longint sat32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic rsp_type closest_point(input req_type w);
      longint a[3], b[3], c[3], p[3], ab[3], ac[3], bc[3], ap[3], bp[3], cp[3];
      longint f, u, v, wa;
      wide_type d1, d2, d3, d4, d5, d6, vp0, vp1, vp2, e43, e56, den;
      rsp_type r;
      a = '{longint'(w.vertex_a_x), longint'(w.vertex_a_y), longint'(w.vertex_a_z)};
      b = '{longint'(w.vertex_b_x), longint'(w.vertex_b_y), longint'(w.vertex_b_z)};
      c = '{longint'(w.vertex_c_x), longint'(w.vertex_c_y), longint'(w.vertex_c_z)};
      p = '{longint'(w.query_x), longint'(w.query_y), longint'(w.query_z)};
      for (int i = 0; i < 3; i++) begin
         ab[i] = b[i] - a[i];
         ac[i] = c[i] - a[i];
         bc[i] = c[i] - b[i];
         ap[i] = p[i] - a[i];
         bp[i] = p[i] - b[i];
         cp[i] = p[i] - c[i];
      end
      r = '0;
      d1 = dot3(ab, ap);
      d2 = dot3(ac, ap);
      d3 = dot3(ab, bp);
      d4 = dot3(ac, bp);
      d5 = dot3(ab, cp);
      d6 = dot3(ac, cp);
      vp2 = d1 * d4 - d2 * d3;
      vp1 = d2 * d5 - d1 * d6;
      vp0 = d3 * d6 - d4 * d5;
      e43 = d4 - d3;
      e56 = d5 - d6;
      if (d1 <= 0 && d2 <= 0) begin
         r.closest_x = coord_type'(a[0]);
         r.closest_y = coord_type'(a[1]);
         r.closest_z = coord_type'(a[2]);
         r.region = REGION_VERTEX_A;
         r.weight_a = WEIGHT_W'(ONE_Q);
      end else if (d3 >= 0 && d4 <= d3) begin
         r.closest_x = coord_type'(b[0]);
         r.closest_y = coord_type'(b[1]);
         r.closest_z = coord_type'(b[2]);
         r.region = REGION_VERTEX_B;
         r.weight_b = WEIGHT_W'(ONE_Q);
      end else if (d6 >= 0 && d5 <= d6) begin
         r.closest_x = coord_type'(c[0]);
         r.closest_y = coord_type'(c[1]);
         r.closest_z = coord_type'(c[2]);
         r.region = REGION_VERTEX_C;
         r.weight_c = WEIGHT_W'(ONE_Q);
      end else if (vp2 <= 0 && d1 >= 0 && d3 <= 0) begin
         f = sat_ratio(d1, floor_one(d1 - d3));
         r.closest_x = coord_type'(sat32(a[0] + round_q(f * ab[0])));
         r.closest_y = coord_type'(sat32(a[1] + round_q(f * ab[1])));
         r.closest_z = coord_type'(sat32(a[2] + round_q(f * ab[2])));
         r.region = REGION_EDGE_AB;
         r.weight_a = WEIGHT_W'(ONE_Q - f);
         r.weight_b = WEIGHT_W'(f);
      end else if (vp1 <= 0 && d2 >= 0 && d6 <= 0) begin
         f = sat_ratio(d2, floor_one(d2 - d6));
         r.closest_x = coord_type'(sat32(a[0] + round_q(f * ac[0])));
         r.closest_y = coord_type'(sat32(a[1] + round_q(f * ac[1])));
         r.closest_z = coord_type'(sat32(a[2] + round_q(f * ac[2])));
         r.region = REGION_EDGE_AC;
         r.weight_a = WEIGHT_W'(ONE_Q - f);
         r.weight_c = WEIGHT_W'(f);
      end else if (vp0 <= 0 && e43 >= 0 && e56 >= 0) begin
         f = sat_ratio(e43, floor_one(e43 + e56));
         r.closest_x = coord_type'(sat32(b[0] + round_q(f * bc[0])));
         r.closest_y = coord_type'(sat32(b[1] + round_q(f * bc[1])));
         r.closest_z = coord_type'(sat32(b[2] + round_q(f * bc[2])));
         r.region = REGION_EDGE_BC;
         r.weight_b = WEIGHT_W'(ONE_Q - f);
         r.weight_c = WEIGHT_W'(f);
      end else begin
         den = floor_one(vp0 + vp1 + vp2);
         u = sat_ratio(vp1, den);
         v = sat_ratio(vp2, den);
         wa = ONE_Q - u - v;
         if (wa < 0) wa = 0;
         r.closest_x = coord_type'(sat32(a[0] + round_q(u * ab[0] + v * ac[0])));
         r.closest_y = coord_type'(sat32(a[1] + round_q(u * ab[1] + v * ac[1])));
         r.closest_z = coord_type'(sat32(a[2] + round_q(u * ab[2] + v * ac[2])));
         r.region = REGION_INTERIOR;
         r.weight_a = WEIGHT_W'(wa);
         r.weight_b = WEIGHT_W'(u);
         r.weight_c = WEIGHT_W'(v);
      end
      return r;
   endfunction

   function automatic coord_type rand_coord(input int spread);
      if (spread == 0) return coord_type'($urandom);
      return coord_type'(int'($urandom_range(0, 2 * spread)) - spread);
   endfunction

   function automatic req_type make_word(input coord_type ax, ay, az, bx, by, bz,
                                         cx, cy, cz, px, py, pz);
      req_type w;
      w.vertex_a_x = ax; w.vertex_a_y = ay; w.vertex_a_z = az;
      w.vertex_b_x = bx; w.vertex_b_y = by; w.vertex_b_z = bz;
      w.vertex_c_x = cx; w.vertex_c_y = cy; w.vertex_c_z = cz;
      w.query_x = px; w.query_y = py; w.query_z = pz;
      return w;
   endfunction

   // idle percentages per phase: none, sender, receiver, both
   function automatic int send_idle_pct();
      if (n_accepted < 400) return 0;
      if (n_accepted < 800) return 69;
      if (n_accepted < 1200) return 0;
      return 17;
   endfunction

   function automatic int recv_idle_pct();
      if (n_accepted < 800) return 0;
      if (n_accepted < 1200) return 69;
      return 17;
   endfunction

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) begin
            expected_points.push_back(closest_point(pending_words.pop_front()));
            n_accepted <= n_accepted + 1;
         end
         if (req_push && req_full) begin
            req_push <= 1'b1;
         end else if (pending_words.size() > 0 &&
                      $urandom_range(0, 99) >= send_idle_pct()) begin
            req_push <= 1'b1;
            req_data <= pending_words[0];
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // long hold-off so the pipeline and its queue back up
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
         end else if (!held_once && n_accepted >= 100) begin
            held_once <= 1'b1;
            hold_cycles <= 200;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_points.size() == 0) begin
               $error("result word with nothing expected");
               n_errors <= n_errors + 1;
            end else begin
               rsp_type e;
               int      bad;
               e = expected_points.pop_front();
               bad = 0;
               if (rsp_data.closest_x !== e.closest_x) begin
                  $error("closest_x expected %0d got %0d", e.closest_x, rsp_data.closest_x);
                  bad++;
               end
               if (rsp_data.closest_y !== e.closest_y) begin
                  $error("closest_y expected %0d got %0d", e.closest_y, rsp_data.closest_y);
                  bad++;
               end
               if (rsp_data.closest_z !== e.closest_z) begin
                  $error("closest_z expected %0d got %0d", e.closest_z, rsp_data.closest_z);
                  bad++;
               end
               if (rsp_data.region !== e.region) begin
                  $error("region expected %0d got %0d", e.region, rsp_data.region);
                  bad++;
               end
               if (rsp_data.weight_a !== e.weight_a) begin
                  $error("weight_a expected %0d got %0d", e.weight_a, rsp_data.weight_a);
                  bad++;
               end
               if (rsp_data.weight_b !== e.weight_b) begin
                  $error("weight_b expected %0d got %0d", e.weight_b, rsp_data.weight_b);
                  bad++;
               end
               if (rsp_data.weight_c !== e.weight_c) begin
                  $error("weight_c expected %0d got %0d", e.weight_c, rsp_data.weight_c);
                  bad++;
               end
               n_errors <= n_errors + bad;
               if (e.region < 7) region_hits[e.region] <= region_hits[e.region] + 1;
               n_checked <= n_checked + 1;
            end
         end
         if (hold_cycles > 0 || (!held_once && n_accepted >= 100)) begin
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(0, 99) >= recv_idle_pct());
         end
      end
   end

   always @(posedge clock) begin
      n_cycles <= n_cycles + 1;
      if (n_cycles > LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      coord_type one, ten, mx, mn;
      int spread;
      one = 32'sd65536;
      ten = 32'sd655360;
      mx = 32'sh7fffffff;
      mn = 32'sh80000000;
      // a query for each region of a right triangle in the xy plane, two for the interior
      pending_words.push_back(make_word(0, 0, 0, ten, 0, 0, 0, ten, 0, -one, -one, one));
      pending_words.push_back(make_word(0, 0, 0, ten, 0, 0, 0, ten, 0, ten + one, -one, 0));
      pending_words.push_back(make_word(0, 0, 0, ten, 0, 0, 0, ten, 0, -one, ten + one, 0));
      pending_words.push_back(make_word(0, 0, 0, ten, 0, 0, 0, ten, 0, 3 * one, -one, one));
      pending_words.push_back(make_word(0, 0, 0, ten, 0, 0, 0, ten, 0, -one, 3 * one, -one));
      pending_words.push_back(make_word(0, 0, 0, ten, 0, 0, 0, ten, 0, ten, ten, 0));
      pending_words.push_back(make_word(0, 0, 0, ten, 0, 0, 0, ten, 0, 2 * one, 3 * one, one));
      pending_words.push_back(make_word(0, 0, 0, ten, 0, 0, 0, ten, 0, 1, 1, -1));
      // degenerate triangles: single point and collinear vertices
      pending_words.push_back(make_word(one, one, one, one, one, one, one, one, one,
                                        0, 0, 0));
      pending_words.push_back(make_word(0, 0, 0, one, 0, 0, 2 * one, 0, 0, one, one, 0));
      pending_words.push_back(make_word(0, 0, 0, ten, 0, 0, ten, 0, 0, 5 * one, one, 0));
      // extremes of the coordinate range
      pending_words.push_back(make_word(mn, mn, mn, mx, mn, mn, mn, mx, mn, 0, 0, mx));
      pending_words.push_back(make_word(mx, mx, mx, mn, mx, mx, mx, mn, mx, 0, 0, 0));
      pending_words.push_back(make_word(mn, mn, mn, mx, mx, mx, mn, mx, mx, mx, mn, mn));
      pending_words.push_back(make_word(mn, 0, 0, mx, 0, 0, 0, mx, 0, 0, 1, 0));
      pending_words.push_back(make_word(mx, mx, mx, mx, mx, mx, mx, mx, mx, mn, mn, mn));
      pending_words.push_back(make_word(mn, mx, 0, mx, mn, 0, mx, mx, 0, 0, 0, mn));
      for (int n = 0; n < N_RANDOM; n++) begin
         case ($urandom_range(0, 9))
            0, 1:    spread = 0;
            2:       spread = 64;
            3, 4:    spread = 1 << 18;
            default: spread = 1 << 22;
         endcase
         pending_words.push_back(make_word(
            rand_coord(spread), rand_coord(spread), rand_coord(spread),
            rand_coord(spread), rand_coord(spread), rand_coord(spread),
            rand_coord(spread), rand_coord(spread), rand_coord(spread),
            rand_coord(spread), rand_coord(spread), rand_coord(spread)));
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      wait (pending_words.size() == 0 && expected_points.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      $display("checked %0d results from %0d words, with a long result stall",
               n_checked, n_accepted);
      $display("regions a/b/c/ab/ac/bc/interior: %0d %0d %0d %0d %0d %0d %0d",
               region_hits[0], region_hits[1], region_hits[2], region_hits[3],
               region_hits[4], region_hits[5], region_hits[6]);
      if (n_errors == 0 && expected_points.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> sim.f
hdl/cpt_pkg.sv
hdl/cpt_front.sv
hdl/cpt_queue.sv
hdl/cpt_back.sv
hdl/closest_point_on_triangle.sv
hdl/cpt_checker.sv
tb/closest_point_on_triangle_tb.sv
